// File: src/double_ended_queue_top_macros.svh
// assertion helpers shared by the deque rtl
`ifndef DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH

// same-cycle implication, masked during reset
`define DEQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked during reset
`define DEQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/deq_pkg.sv
package deq_pkg;

   localparam int DATA_W        = 32;
   localparam int DEFAULT_DEPTH = 16;
   localparam int DEFAULT_OCC_W = $clog2(DEFAULT_DEPTH + 1);

   localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
   localparam logic [1:0] REQ_PUSH_BACK  = 2'd1;
   localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
   localparam logic [1:0] REQ_POP_BACK   = 2'd3;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam logic signed [DATA_W-1:0] NEG_ONE = '1;

   // controller to datapath
   typedef struct packed {
      logic do_op;
      logic do_fetch;
   } deq_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic need_fetch;
   } deq_stat_type;

endpackage

// File: src/deq_if.sv
interface deq_req_if;
   import deq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [1:0]               req_type;
   logic signed [DATA_W-1:0] push_value;

   modport source (output valid, output req_type, output push_value, input ready);
   modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface deq_rsp_if #(
   parameter int OCC_W = deq_pkg::DEFAULT_OCC_W
);
   import deq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [1:0]               status;
   logic signed [DATA_W-1:0] popped_value;
   logic signed [DATA_W-1:0] front_value;
   logic signed [DATA_W-1:0] back_value;
   logic                     is_empty;
   logic                     is_full;
   logic [OCC_W-1:0]         occupancy;

   modport source (output valid, output status, output popped_value, output front_value,
                   output back_value, output is_empty, output is_full, output occupancy,
                   input ready);
   modport sink   (input valid, input status, input popped_value, input front_value,
                   input back_value, input is_empty, input is_full, input occupancy,
                   output ready);
endinterface

// File: src/deq_ctrl.sv
`include "double_ended_queue_top_macros.svh"

module deq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  deq_pkg::deq_stat_type stat,
   output deq_pkg::deq_cmd_type  cmd
);
   import deq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE  = 2'b01,
      S_FETCH = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;

   // output register is free if empty or drained this cycle
   assign out_free     = !rsp_valid_ff || rsp_ready;
   // no word is taken while reset is held
   assign req_ready    = !reset && (state_ff == S_IDLE) && out_free;
   assign accept       = req_valid && req_ready;
   assign cmd.do_op    = accept;
   assign cmd.do_fetch = (state_ff == S_FETCH) && out_free;
   assign rsp_valid    = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && stat.need_fetch) state_in = S_FETCH;
         end
         S_FETCH: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if ((accept && !stat.need_fetch) || cmd.do_fetch) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `DEQ_ASSERT_NEXT(a_fetch_finishes, clock, reset, cmd.do_fetch, (state_ff == S_IDLE) && rsp_valid_ff, "fetch did not finish with a result")
   `DEQ_ASSERT_NEXT(a_short_op_result, clock, reset, accept && !stat.need_fetch, rsp_valid_ff && (state_ff == S_IDLE), "one-cycle request gave no result")
   `DEQ_ASSERT_NEXT(a_pop_waits, clock, reset, accept && stat.need_fetch, (state_ff == S_FETCH) && !req_ready, "pop did not wait for the store read")

endmodule

// File: src/deq_dp.sv
`include "double_ended_queue_top_macros.svh"

module deq_dp #(
   parameter int DEPTH = deq_pkg::DEFAULT_DEPTH,
   parameter int OCC_W = $clog2(DEPTH + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  deq_pkg::deq_cmd_type             cmd,
   output deq_pkg::deq_stat_type            stat,
   input  logic [1:0]                       req_type,
   input  logic signed [deq_pkg::DATA_W-1:0] push_value,
   output logic [1:0]                       status,
   output logic signed [deq_pkg::DATA_W-1:0] popped_value,
   output logic signed [deq_pkg::DATA_W-1:0] front_value,
   output logic signed [deq_pkg::DATA_W-1:0] back_value,
   output logic                             is_empty,
   output logic                             is_full,
   output logic [OCC_W-1:0]                 occupancy
);
   import deq_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic signed [DATA_W-1:0] mem [DEPTH];

   logic [AW-1:0]            front_idx_ff, front_idx_in;
   logic [AW-1:0]            back_idx_ff, back_idx_in;
   logic [OCC_W-1:0]         count_ff, count_in;
   logic signed [DATA_W-1:0] front_val_ff, front_val_in;
   logic signed [DATA_W-1:0] back_val_ff, back_val_in;
   logic signed [DATA_W-1:0] pend_pop_ff;
   logic                     pend_front_ff;
   logic signed [DATA_W-1:0] rd_data_ff;

   logic [AW-1:0]            front_inc, front_dec, back_inc, back_dec;
   logic [AW-1:0]            wr_addr, rd_addr;
   logic                     wr_en, rd_en;
   logic                     is_push, now_empty, now_full;
   logic                     load;
   logic [1:0]               status_in;
   logic signed [DATA_W-1:0] popped_in;

   logic [1:0]               status_ff;
   logic signed [DATA_W-1:0] popped_ff, front_out_ff, back_out_ff;
   logic                     empty_ff, full_ff;
   logic [OCC_W-1:0]         occ_ff;

   assign is_push   = (req_type == REQ_PUSH_FRONT) || (req_type == REQ_PUSH_BACK);
   assign now_empty = (count_ff == '0);
   assign now_full  = (count_ff == OCC_W'(DEPTH));
   assign stat.need_fetch = !is_push && !now_empty;

   // ring wrap for depths that are not a power of two
   assign front_inc = (front_idx_ff == AW'(DEPTH - 1)) ? '0 : front_idx_ff + 1'b1;
   assign front_dec = (front_idx_ff == '0) ? AW'(DEPTH - 1) : front_idx_ff - 1'b1;
   assign back_inc  = (back_idx_ff == AW'(DEPTH - 1)) ? '0 : back_idx_ff + 1'b1;
   assign back_dec  = (back_idx_ff == '0) ? AW'(DEPTH - 1) : back_idx_ff - 1'b1;

   always_comb begin
      front_idx_in = front_idx_ff;
      back_idx_in  = back_idx_ff;
      count_in     = count_ff;
      front_val_in = front_val_ff;
      back_val_in  = back_val_ff;
      wr_en        = 1'b0;
      wr_addr      = front_dec;
      rd_en        = 1'b0;
      rd_addr      = front_inc;
      load         = 1'b0;
      status_in    = STATUS_DONE;
      popped_in    = NEG_ONE;
      if (cmd.do_op) begin
         if (is_push) begin
            load = 1'b1;
            if (now_full) begin
               status_in = STATUS_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               if (req_type == REQ_PUSH_FRONT) begin
                  front_idx_in = front_dec;
                  wr_addr      = front_dec;
                  front_val_in = push_value;
                  if (now_empty) back_val_in = push_value;
               end else begin
                  back_idx_in = back_inc;
                  wr_addr     = back_inc;
                  back_val_in = push_value;
                  if (now_empty) front_val_in = push_value;
               end
            end
         end else if (now_empty) begin
            load      = 1'b1;
            status_in = STATUS_EMPTY;
         end else begin
            // new end word comes from the registered store read, taken in the fetch state
            rd_en    = 1'b1;
            count_in = count_ff - 1'b1;
            if (req_type == REQ_POP_FRONT) begin
               front_idx_in = front_inc;
               rd_addr      = front_inc;
            end else begin
               back_idx_in = back_dec;
               rd_addr     = back_dec;
            end
         end
      end else if (cmd.do_fetch) begin
         load      = 1'b1;
         popped_in = pend_pop_ff;
         if (pend_front_ff) begin
            front_val_in = rd_data_ff;
         end else begin
            back_val_in = rd_data_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= push_value;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_idx_ff <= '0;
         back_idx_ff  <= AW'(DEPTH - 1);
         count_ff     <= '0;
      end else begin
         front_idx_ff <= front_idx_in;
         back_idx_ff  <= back_idx_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      front_val_ff <= front_val_in;
      back_val_ff  <= back_val_in;
      if (rd_en) begin
         pend_pop_ff   <= (req_type == REQ_POP_FRONT) ? front_val_ff : back_val_ff;
         pend_front_ff <= (req_type == REQ_POP_FRONT);
      end
      if (load) begin
         status_ff    <= status_in;
         popped_ff    <= popped_in;
         front_out_ff <= (count_in == '0) ? NEG_ONE : front_val_in;
         back_out_ff  <= (count_in == '0) ? NEG_ONE : back_val_in;
         empty_ff     <= (count_in == '0);
         full_ff      <= (count_in == OCC_W'(DEPTH));
         occ_ff       <= count_in;
      end
   end

   assign status       = status_ff;
   assign popped_value = popped_ff;
   assign front_value  = front_out_ff;
   assign back_value   = back_out_ff;
   assign is_empty     = empty_ff;
   assign is_full      = full_ff;
   assign occupancy    = occ_ff;

   `DEQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= OCC_W'(DEPTH), "count above depth")
   `DEQ_ASSERT_NEXT(a_full_push_holds, clock, reset, cmd.do_op && is_push && now_full, $stable(count_ff) && $stable(front_idx_ff) && $stable(back_idx_ff), "rejected push changed state")
   `DEQ_ASSERT_NEXT(a_empty_pop_holds, clock, reset, cmd.do_op && !is_push && now_empty, $stable(count_ff) && $stable(front_idx_ff) && $stable(back_idx_ff), "empty pop changed state")

endmodule

// File: src/double_ended_queue_top.sv
// channel   dir  handshake          payload
// req_chan  in   valid / ready      req_type, push_value
// rsp_chan  out  valid / ready      status, popped_value, front_value, back_value,
//                                   is_empty, is_full, occupancy
//
// a push, a rejected push and a pop on an empty queue load the result directly; a pop that
// removes a word passes through the fetch state, for the registered store read that brings
// in the new front or back word
// reset is synchronous and clears indices and count; the element store is not cleared
// each result sits in an output register, a new word is taken while it is drained
// a stalled rsp_chan holds requests off once the next result has nowhere to go
module double_ended_queue_top #(
   parameter int DEPTH = deq_pkg::DEFAULT_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   deq_req_if.sink   req_chan,
   deq_rsp_if.source rsp_chan
);
   import deq_pkg::*;

   localparam int OCC_W = $clog2(DEPTH + 1);

   deq_cmd_type  cmd;
   deq_stat_type stat;

   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   deq_dp #(
      .DEPTH (DEPTH),
      .OCC_W (OCC_W)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_type     (req_chan.req_type),
      .push_value   (req_chan.push_value),
      .status       (rsp_chan.status),
      .popped_value (rsp_chan.popped_value),
      .front_value  (rsp_chan.front_value),
      .back_value   (rsp_chan.back_value),
      .is_empty     (rsp_chan.is_empty),
      .is_full      (rsp_chan.is_full),
      .occupancy    (rsp_chan.occupancy)
   );

endmodule
